FILE: hdl/pms_pkg.sv
// Shared types, constants and the pitch table for the PWM melody sequencer.
`timescale 1ns / 1ps

package pms_pkg;

	localparam int unsigned NOTE_DEPTH_DEF = 256;

	localparam int unsigned RATE_W   = 24;
	localparam int unsigned CODE_W   = 8;
	localparam int unsigned QUART_W  = 6;
	localparam int unsigned ADDR_W   = 8;
	localparam int unsigned CNT_W    = 16;
	localparam int unsigned HZ_W     = 11;
	localparam int unsigned PROD_W   = QUART_W + RATE_W;
	localparam int unsigned DIV_DW   = PROD_W - 2;
	localparam int unsigned DIV_VW   = CNT_W;

	localparam logic [RATE_W-1:0]  TICK_RATE_RST = 24'd1000000;
	localparam logic [RATE_W-1:0]  BEAT_LEN_RST  = 24'd500000;
	localparam logic [CODE_W-1:0]  END_CODE      = 8'd255;
	localparam logic [CNT_W-1:0]   REST_PERIOD   = 16'd5000;
	localparam logic [CNT_W-1:0]   CNT_MAX       = 16'hFFFF;

	// configuration register indexes
	localparam logic CFG_TICK_RATE = 1'b0;
	localparam logic CFG_BEAT_LEN  = 1'b1;

	// action codes of an input item
	localparam logic [1:0] ACT_TICK  = 2'd0;
	localparam logic [1:0] ACT_WRITE = 2'd1;
	localparam logic [1:0] ACT_START = 2'd2;

	typedef struct packed {
		logic [1:0]         action;
		logic [ADDR_W-1:0]  entry_address;
		logic [CODE_W-1:0]  note_code;
		logic [QUART_W-1:0] beat_quarters;
	} pms_in_t;

	typedef struct packed {
		logic tone_out;
		logic playing;
		logic song_finished;
	} pms_out_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXEC,
		ST_READ,
		ST_CHECK,
		ST_DIV1,
		ST_PER,
		ST_MUL,
		ST_LOAD2,
		ST_DIV2,
		ST_CNT,
		ST_DONE
	} pms_state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_TICK,
		OP_WRITE,
		OP_START,
		OP_READ,
		OP_NOTE,
		OP_END,
		OP_PERIOD,
		OP_MUL,
		OP_LOAD2,
		OP_COUNT,
		OP_CAPTURE
	} pms_op_t;

	typedef struct packed {
		logic    latch;
		pms_op_t op;
	} pms_cmd_t;

	typedef struct packed {
		logic [1:0] action;
		logic       advance;
		logic       end_code;
		logic       rest;
		logic       div_busy;
		logic       out_free;
	} pms_stat_t;

	function automatic logic [HZ_W-1:0] pitch_hz(input logic [CODE_W-1:0] code);
		logic [HZ_W-1:0] hz;
		unique case (code)
			8'd1:    hz = 11'd262;
			8'd2:    hz = 11'd294;
			8'd3:    hz = 11'd330;
			8'd4:    hz = 11'd349;
			8'd5:    hz = 11'd392;
			8'd6:    hz = 11'd440;
			8'd7:    hz = 11'd494;
			8'd11:   hz = 11'd523;
			8'd12:   hz = 11'd587;
			8'd13:   hz = 11'd659;
			8'd14:   hz = 11'd698;
			8'd15:   hz = 11'd784;
			8'd16:   hz = 11'd880;
			8'd17:   hz = 11'd988;
			8'd21:   hz = 11'd1046;
			8'd22:   hz = 11'd1175;
			8'd23:   hz = 11'd1318;
			8'd24:   hz = 11'd1397;
			8'd25:   hz = 11'd1568;
			8'd26:   hz = 11'd1760;
			8'd27:   hz = 11'd1976;
			default: hz = '0;
		endcase
		return hz;
	endfunction

endpackage

FILE: hdl/pms_div.sv
// Serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module pms_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [pms_pkg::DIV_DW-1:0]  dividend,
	input  logic [pms_pkg::DIV_VW-1:0]  divisor,
	output logic                        busy,
	output logic [pms_pkg::DIV_DW-1:0]  quotient
);
	import pms_pkg::*;

	localparam int unsigned CW = $clog2(DIV_DW + 1);
	localparam logic [CW-1:0] STEPS = CW'(DIV_DW);

	logic [CW-1:0]     cnt_q;
	logic [DIV_VW-1:0] rem_q;
	logic [DIV_VW-1:0] dvs_q;
	logic [DIV_DW-1:0] quo_q;
	logic [DIV_VW:0]   trial;
	logic [DIV_VW:0]   diff;
	logic              ge;

	assign trial = {rem_q, quo_q[DIV_DW-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= STEPS;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// dividend bits shift out the top while quotient bits shift in below
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[DIV_VW-1:0] : trial[DIV_VW-1:0];
			quo_q <= {quo_q[DIV_DW-2:0], ge};
		end
	end

	assign busy     = cnt_q != '0;
	assign quotient = quo_q;

endmodule

FILE: hdl/pms_dpath.sv
// Datapath: note memory, playback registers, divider, output register.
`timescale 1ns / 1ps

module pms_dpath #(
	parameter int unsigned NOTE_DEPTH = pms_pkg::NOTE_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  pms_pkg::pms_cmd_t           cmd,
	output pms_pkg::pms_stat_t          stat,
	input  pms_pkg::pms_in_t            item,
	input  logic                        cfg_valid,
	input  logic                        cfg_index,
	input  logic [pms_pkg::RATE_W-1:0]  cfg_data,
	output logic                        result_valid,
	input  logic                        result_stall,
	output pms_pkg::pms_out_t           result
);
	import pms_pkg::*;

	localparam int unsigned AW = $clog2(NOTE_DEPTH);
	localparam int unsigned MW = CODE_W + QUART_W;

	logic [RATE_W-1:0]  tick_rate_q;
	logic [RATE_W-1:0]  beat_len_q;
	pms_in_t            item_q;
	logic [MW-1:0]      mem [NOTE_DEPTH];
	logic [MW-1:0]      rd_q;
	logic [ADDR_W-1:0]  ptr_q;
	logic [CNT_W-1:0]   period_q;
	logic [CNT_W-1:0]   compare_q;
	logic [CNT_W-1:0]   pcount_q;
	logic [CNT_W-1:0]   ppn_q;
	logic [CNT_W-1:0]   pdone_q;
	logic               active_q;
	logic               fin_q;
	logic [PROD_W-1:0]  prod_q;
	logic               out_valid_q;
	pms_out_t           out_q;

	logic [AW-1:0]      slot_lut [256];
	logic [CODE_W-1:0]  rd_code;
	logic [QUART_W-1:0] rd_quart;
	logic [HZ_W-1:0]    hz;
	logic [CNT_W-1:0]   cnt_inc;
	logic               period_wrap;
	logic [CNT_W-1:0]   pdone_inc;
	logic               div_start;
	logic [DIV_DW-1:0]  div_dividend;
	logic [DIV_VW-1:0]  div_divisor;
	logic               div_busy;
	logic [DIV_DW-1:0]  div_quot;
	logic [CNT_W-1:0]   quot_sat;

	// address folding onto the memory depth, worked out at elaboration
	for (genvar g = 0; g < 256; g++) begin : g_slot
		assign slot_lut[g] = AW'(g % NOTE_DEPTH);
	end

	assign rd_code  = rd_q[MW-1:QUART_W];
	assign rd_quart = rd_q[QUART_W-1:0];
	assign hz       = pitch_hz(rd_code);

	assign cnt_inc     = pcount_q + 1'b1;
	assign period_wrap = cnt_inc >= period_q;
	assign pdone_inc   = (pdone_q == CNT_MAX) ? pdone_q : pdone_q + 1'b1;

	// quotient clamped into 1..65535
	always_comb begin
		if (div_quot == '0) begin
			quot_sat = CNT_W'(1);
		end else if (div_quot > DIV_DW'(CNT_MAX)) begin
			quot_sat = CNT_MAX;
		end else begin
			quot_sat = div_quot[CNT_W-1:0];
		end
	end

	assign div_start    = (cmd.op == OP_NOTE && hz != '0) || cmd.op == OP_LOAD2;
	assign div_dividend = (cmd.op == OP_LOAD2) ? prod_q[PROD_W-1:2] : DIV_DW'(tick_rate_q);
	assign div_divisor  = (cmd.op == OP_LOAD2) ? period_q : DIV_VW'(hz);

	pms_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.quotient (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_rate_q <= TICK_RATE_RST;
			beat_len_q  <= BEAT_LEN_RST;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_TICK_RATE) begin
				tick_rate_q <= cfg_data;
			end else begin
				beat_len_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			item_q <= item;
		end
		if (cmd.op == OP_WRITE) begin
			mem[slot_lut[item_q.entry_address]] <= {item_q.note_code, item_q.beat_quarters};
		end
		if (cmd.op == OP_READ) begin
			rd_q <= mem[slot_lut[ptr_q]];
		end
		if (cmd.op == OP_MUL) begin
			prod_q <= PROD_W'(rd_quart) * PROD_W'(beat_len_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q     <= '0;
			period_q  <= '0;
			compare_q <= '0;
			pcount_q  <= '0;
			ppn_q     <= '0;
			pdone_q   <= '0;
			active_q  <= 1'b0;
			fin_q     <= 1'b0;
		end else begin
			if (cmd.latch) begin
				fin_q <= 1'b0;
			end
			unique case (cmd.op)
				OP_TICK: begin
					if (active_q) begin
						if (period_wrap) begin
							pcount_q <= '0;
							pdone_q  <= pdone_inc;
						end else begin
							pcount_q <= cnt_inc;
						end
					end
				end
				OP_START: ptr_q <= item_q.entry_address;
				OP_NOTE: begin
					if (hz == '0) begin
						period_q  <= REST_PERIOD;
						compare_q <= '0;
					end
				end
				OP_END: begin
					active_q  <= 1'b0;
					compare_q <= '0;
					pcount_q  <= '0;
					pdone_q   <= '0;
					fin_q     <= 1'b1;
				end
				OP_PERIOD: begin
					period_q  <= quot_sat;
					compare_q <= quot_sat >> 1;
				end
				OP_COUNT: begin
					ppn_q    <= quot_sat;
					pcount_q <= '0;
					pdone_q  <= '0;
					ptr_q    <= ptr_q + 1'b1;
					active_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == OP_CAPTURE) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_CAPTURE) begin
			out_q.tone_out      <= active_q && (pcount_q < compare_q);
			out_q.playing       <= active_q;
			out_q.song_finished <= fin_q;
		end
	end

	assign stat.action   = item_q.action;
	assign stat.advance  = active_q && period_wrap && (pdone_inc >= ppn_q);
	assign stat.end_code = rd_code == END_CODE;
	assign stat.rest     = hz == '0;
	assign stat.div_busy = div_busy;
	assign stat.out_free = !out_valid_q || !result_stall;

	assign result_valid = out_valid_q;
	assign result       = out_q;

	a_active_period: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (period_q != '0 && ppn_q != '0))
		else $error("playing with a zero period or zero note length");

	a_compare_below: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> compare_q < period_q)
		else $error("compare value not below period");

	a_div_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider restarted while busy");

	a_finished_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_q.song_finished || !out_q.playing)) |-> !out_q.tone_out)
		else $error("tone high while not playing");

endmodule

FILE: hdl/pms_ctrl.sv
// Controller state machine that sequences item handling and note loads.
`timescale 1ns / 1ps

module pms_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  pms_pkg::pms_stat_t  stat,
	output pms_pkg::pms_cmd_t   cmd
);
	import pms_pkg::*;

	pms_state_t state_q;
	pms_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd.latch  = 1'b0;
		cmd.op     = OP_NONE;
		item_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				item_stall = 1'b0;
				if (item_valid) begin
					cmd.latch = 1'b1;
					state_d   = ST_EXEC;
				end
			end
			ST_EXEC: begin
				unique case (stat.action)
					ACT_TICK: begin
						cmd.op  = OP_TICK;
						state_d = stat.advance ? ST_READ : ST_DONE;
					end
					ACT_WRITE: begin
						cmd.op  = OP_WRITE;
						state_d = ST_DONE;
					end
					ACT_START: begin
						cmd.op  = OP_START;
						state_d = ST_READ;
					end
					default: state_d = ST_DONE;
				endcase
			end
			ST_READ: begin
				cmd.op  = OP_READ;
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (stat.end_code) begin
					cmd.op  = OP_END;
					state_d = ST_DONE;
				end else begin
					// a rest sets its period here and skips the first divide
					cmd.op  = OP_NOTE;
					state_d = stat.rest ? ST_MUL : ST_DIV1;
				end
			end
			ST_DIV1: begin
				if (!stat.div_busy) begin
					state_d = ST_PER;
				end
			end
			ST_PER: begin
				cmd.op  = OP_PERIOD;
				state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.op  = OP_MUL;
				state_d = ST_LOAD2;
			end
			ST_LOAD2: begin
				cmd.op  = OP_LOAD2;
				state_d = ST_DIV2;
			end
			ST_DIV2: begin
				if (!stat.div_busy) begin
					state_d = ST_CNT;
				end
			end
			ST_CNT: begin
				cmd.op  = OP_COUNT;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd.op  = OP_CAPTURE;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

FILE: hdl/pwm_melody_sequencer.sv
// Top level of the PWM melody sequencer.
`timescale 1ns / 1ps

// Items are handled one at a time and each yields one result. A write, a
// tick that stays within the current note, or an unused action goes from
// its execute state straight to the result. A start, or a tick that moves
// to the next entry, loads a note with the one serial divider, which first
// makes the period from the tick rate and then the period count from the
// note length; a rest takes REST_PERIOD and skips the first divide. An end
// code stops playback without a divide. A finished result waits in the
// output register while the next item is taken in. The note memory has no
// reset; read only entries that were written. Config writes are taken
// every cycle and must only occur while no item is in flight.
module pwm_melody_sequencer #(
	parameter int unsigned NOTE_DEPTH = pms_pkg::NOTE_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_stall,
	input  pms_pkg::pms_in_t            item,
	output logic                        result_valid,
	input  logic                        result_stall,
	output pms_pkg::pms_out_t           result,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic                        cfg_index,
	input  logic [pms_pkg::RATE_W-1:0]  cfg_data
);
	import pms_pkg::*;

	pms_cmd_t  cmd;
	pms_stat_t stat;

	assign cfg_ready = 1'b1;

	pms_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.stat       (stat),
		.cmd        (cmd)
	);

	pms_dpath #(
		.NOTE_DEPTH (NOTE_DEPTH)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.item         (item),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
